/* rtl/pasu_pkg.sv */
// ----------------------------------------------------------------------------
// Positional array store: shared package
// Mode and status codes, the command passed from front to back, the result
// item and the state type of the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pasu_pkg;

	// Input mode codes
	localparam logic [2:0] MODE_APPEND   = 3'd0;
	localparam logic [2:0] MODE_INSERT   = 3'd1;
	localparam logic [2:0] MODE_DELETE   = 3'd2;
	localparam logic [2:0] MODE_SEARCH   = 3'd3;
	localparam logic [2:0] MODE_READ_ALL = 3'd4;
	localparam logic [2:0] MODE_CLEAR    = 3'd5;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_POS   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// Most results given for one input item
	localparam logic [6:0] MaxOut = 7'd64;

	typedef enum logic [2:0] {
		K_APPEND,
		K_INSERT,
		K_DELETE,
		K_SEARCH,
		K_READ_ALL,
		K_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  pos;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  found_position;
		logic [31:0] element;
		logic [6:0]  entry_count;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SHIFT_UP,
		BK_SHIFT_DN,
		BK_SCAN,
		BK_RESP
	} bk_state_t;

endpackage

`default_nettype wire

/* rtl/pasu_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module pasu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/pasu_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats, decodes the mode into a command kind and pushes
// valid commands into the queue; unused modes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pasu_front (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [39:0]   s_tdata,
	input  wire logic [2:0]    s_tuser,
	input  wire logic          q_full,
	output logic               push,
	output pasu_pkg::cmd_t     push_cmd
);

	logic kind_ok;

	assign s_tready = !q_full;

	// Decode mode into command kind, pass position and value through
	always_comb begin
		kind_ok        = 1'b1;
		push_cmd.kind  = pasu_pkg::K_APPEND;
		push_cmd.pos   = s_tdata[6:0];
		push_cmd.value = s_tdata[38:7];
		unique case (s_tuser)
			pasu_pkg::MODE_APPEND:   push_cmd.kind = pasu_pkg::K_APPEND;
			pasu_pkg::MODE_INSERT:   push_cmd.kind = pasu_pkg::K_INSERT;
			pasu_pkg::MODE_DELETE:   push_cmd.kind = pasu_pkg::K_DELETE;
			pasu_pkg::MODE_SEARCH:   push_cmd.kind = pasu_pkg::K_SEARCH;
			pasu_pkg::MODE_READ_ALL: push_cmd.kind = pasu_pkg::K_READ_ALL;
			pasu_pkg::MODE_CLEAR:    push_cmd.kind = pasu_pkg::K_CLEAR;
			default:                 kind_ok       = 1'b0;
		endcase
	end

	// Push only decodable beats
	assign push = s_tvalid && s_tready && kind_ok;

endmodule

`default_nettype wire

/* rtl/pasu_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry register queue between the front end and the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pasu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pasu_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output pasu_pkg::cmd_t       head_cmd
);

	pasu_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_cmd   = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Store payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

/* rtl/pasu_back.sv */
// ----------------------------------------------------------------------------
// Back sequencer
// Executes one command at a time against the entry RAM: shifts entries for
// insert and delete, walks them for search and read-all, and drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pasu_back #(
	parameter int DEPTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire pasu_pkg::cmd_t  q_cmd,
	output logic                 q_pop,
	output logic                 res_valid,
	output pasu_pkg::result_t    res,
	input  wire logic            res_ready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	pasu_pkg::bk_state_t state_q, state_d;
	pasu_pkg::cmd_kind_t kind_q;

	logic [CW-1:0]  count_q;
	logic [31:0]    val_q;
	logic [AW-1:0]  lo_q;
	logic [AW-1:0]  rd_idx_q;
	logic           rd_more_q;
	logic           vld_s1;
	logic [AW-1:0]  idx_s1;
	logic           pend_v_q;
	logic [6:0]     pend_pos_q;
	logic [31:0]    pend_elem_q;
	logic [6:0]     nres_q;
	logic [2:0]     resp_st_q;
	logic           out_v_q;
	pasu_pkg::result_t out_q;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [31:0]    mem_wdata;
	logic           rd_issue;
	logic [31:0]    rd_data;

	logic           out_free;
	logic           out_ld;
	pasu_pkg::result_t out_d;

	logic [PW-1:0]  hd_pos;
	logic [PW-1:0]  cnt_w;
	logic           pos_bad;
	logic           is_full;
	logic           is_match;
	logic           match_eff;
	logic           consume;
	logic           shift_done;
	logic           scan_done;
	logic [6:0]     s1_pos;

	pasu_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_issue),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// Classify the head command against the current count
	assign hd_pos  = PW'(q_cmd.pos);
	assign cnt_w   = PW'(count_q);
	assign pos_bad = (hd_pos == '0) || (hd_pos > cnt_w);
	assign is_full = (count_q == FullCnt);

	// Scan compare on returned read data
	assign is_match  = (kind_q == pasu_pkg::K_READ_ALL) || (rd_data == val_q);
	assign match_eff = vld_s1 && is_match && (nres_q != pasu_pkg::MaxOut);
	assign out_free  = !out_v_q || res_ready;
	assign s1_pos    = 7'(PW'(idx_s1) + PW'(1));

	assign shift_done = !rd_more_q && !vld_s1;
	assign scan_done  = (!rd_more_q || (nres_q == pasu_pkg::MaxOut)) && !vld_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pasu_pkg::BK_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.kind)
						pasu_pkg::K_INSERT: begin
							if (!pos_bad && !is_full) begin
								state_d = pasu_pkg::BK_SHIFT_UP;
							end else begin
								state_d = pasu_pkg::BK_RESP;
							end
						end
						pasu_pkg::K_DELETE: begin
							if (count_q != '0 && !pos_bad && hd_pos != cnt_w) begin
								state_d = pasu_pkg::BK_SHIFT_DN;
							end else begin
								state_d = pasu_pkg::BK_RESP;
							end
						end
						pasu_pkg::K_SEARCH,
						pasu_pkg::K_READ_ALL: state_d = pasu_pkg::BK_SCAN;
						default:              state_d = pasu_pkg::BK_RESP;
					endcase
				end
			end
			pasu_pkg::BK_SHIFT_UP,
			pasu_pkg::BK_SHIFT_DN: begin
				if (shift_done) begin
					state_d = pasu_pkg::BK_RESP;
				end
			end
			pasu_pkg::BK_SCAN: begin
				if (scan_done && out_free) begin
					state_d = pasu_pkg::BK_IDLE;
				end
			end
			pasu_pkg::BK_RESP: begin
				if (out_free) begin
					state_d = pasu_pkg::BK_IDLE;
				end
			end
			default: state_d = pasu_pkg::BK_IDLE;
		endcase
	end

	// Control outputs: queue pop, RAM ports, output load
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		rd_issue  = 1'b0;
		consume   = vld_s1;
		out_ld    = 1'b0;
		out_d     = '0;
		out_d.entry_count = 7'(count_q);
		unique case (state_q)
			pasu_pkg::BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_cmd.kind == pasu_pkg::K_APPEND && !is_full) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(count_q);
					mem_wdata = q_cmd.value;
				end
			end
			pasu_pkg::BK_SHIFT_UP: begin
				rd_issue = rd_more_q;
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 + AW'(1);
					mem_wdata = rd_data;
				end else if (shift_done) begin
					mem_we    = 1'b1;
					mem_waddr = lo_q;
					mem_wdata = val_q;
				end
			end
			pasu_pkg::BK_SHIFT_DN: begin
				rd_issue = rd_more_q;
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 - AW'(1);
					mem_wdata = rd_data;
				end
			end
			pasu_pkg::BK_SCAN: begin
				consume  = vld_s1 && (!match_eff || !pend_v_q || out_free);
				rd_issue = rd_more_q && (nres_q != pasu_pkg::MaxOut) &&
					(!vld_s1 || consume);
				if (consume && match_eff && pend_v_q) begin
					// Release the held match; a newer one follows it
					out_ld               = 1'b1;
					out_d.status         = pasu_pkg::ST_OK;
					out_d.found_position = pend_pos_q;
					out_d.element        = pend_elem_q;
				end else if (scan_done && out_free) begin
					out_ld     = 1'b1;
					out_d.last = 1'b1;
					if (pend_v_q) begin
						out_d.status         = pasu_pkg::ST_OK;
						out_d.found_position = pend_pos_q;
						out_d.element        = pend_elem_q;
					end else if (kind_q == pasu_pkg::K_SEARCH) begin
						out_d.status = pasu_pkg::ST_NOT_FOUND;
					end else begin
						out_d.status = pasu_pkg::ST_EMPTY;
					end
				end
			end
			pasu_pkg::BK_RESP: begin
				out_ld       = out_free;
				out_d.status = resp_st_q;
				out_d.last   = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pasu_pkg::BK_IDLE;
			count_q   <= '0;
			rd_more_q <= 1'b0;
			vld_s1    <= 1'b0;
			pend_v_q  <= 1'b0;
			nres_q    <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// Read pipeline valid
			if (rd_issue) begin
				vld_s1 <= 1'b1;
			end else if (consume) begin
				vld_s1 <= 1'b0;
			end

			// Output register valid
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				pasu_pkg::BK_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.kind)
							pasu_pkg::K_APPEND: begin
								if (!is_full) begin
									count_q <= count_q + CW'(1);
								end
							end
							pasu_pkg::K_INSERT: begin
								rd_more_q <= 1'b1;
							end
							pasu_pkg::K_DELETE: begin
								if (count_q != '0 && !pos_bad) begin
									if (hd_pos == cnt_w) begin
										count_q <= count_q - CW'(1);
									end else begin
										rd_more_q <= 1'b1;
									end
								end
							end
							pasu_pkg::K_SEARCH,
							pasu_pkg::K_READ_ALL: begin
								rd_more_q <= (count_q != '0);
								pend_v_q  <= 1'b0;
								nres_q    <= '0;
							end
							pasu_pkg::K_CLEAR: begin
								count_q <= '0;
							end
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				pasu_pkg::BK_SHIFT_UP: begin
					if (rd_issue) begin
						rd_more_q <= (rd_idx_q != lo_q);
					end
					if (shift_done) begin
						count_q <= count_q + CW'(1);
					end
				end
				pasu_pkg::BK_SHIFT_DN: begin
					if (rd_issue) begin
						rd_more_q <= (rd_idx_q != lo_q);
					end
					if (shift_done) begin
						count_q <= count_q - CW'(1);
					end
				end
				pasu_pkg::BK_SCAN: begin
					if (rd_issue) begin
						rd_more_q <= ((CW'(rd_idx_q) + CW'(1)) != count_q);
					end
					if (consume && match_eff) begin
						pend_v_q <= 1'b1;
						nres_q   <= nres_q + 7'd1;
					end else if (scan_done && out_free) begin
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					rd_more_q <= rd_more_q;
				end
			endcase
		end
	end

	// Command payload, addresses and held match
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_cmd.kind;
			val_q  <= q_cmd.value;
			if (q_cmd.kind == pasu_pkg::K_INSERT) begin
				rd_idx_q <= AW'(count_q - CW'(1));
				lo_q     <= AW'(hd_pos - PW'(1));
			end else if (q_cmd.kind == pasu_pkg::K_DELETE) begin
				rd_idx_q <= AW'(q_cmd.pos);
				lo_q     <= AW'(count_q - CW'(1));
			end else begin
				rd_idx_q <= '0;
				lo_q     <= '0;
			end
			// Single-result status
			priority if (q_cmd.kind == pasu_pkg::K_APPEND && is_full) begin
				resp_st_q <= pasu_pkg::ST_FULL;
			end else if (q_cmd.kind == pasu_pkg::K_DELETE && count_q == '0) begin
				resp_st_q <= pasu_pkg::ST_EMPTY;
			end else if ((q_cmd.kind == pasu_pkg::K_INSERT ||
					q_cmd.kind == pasu_pkg::K_DELETE) && pos_bad) begin
				resp_st_q <= pasu_pkg::ST_BAD_POS;
			end else if (q_cmd.kind == pasu_pkg::K_INSERT && is_full) begin
				resp_st_q <= pasu_pkg::ST_FULL;
			end else begin
				resp_st_q <= pasu_pkg::ST_OK;
			end
		end else if (rd_issue) begin
			// Step the walk down for insert, up otherwise
			if (state_q == pasu_pkg::BK_SHIFT_UP) begin
				rd_idx_q <= rd_idx_q - AW'(1);
			end else begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
		if (rd_issue) begin
			idx_s1 <= rd_idx_q;
		end
		if (state_q == pasu_pkg::BK_SCAN && consume && match_eff) begin
			pend_pos_q  <= s1_pos;
			pend_elem_q <= rd_data;
		end
		if (out_ld) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule

`default_nettype wire

/* rtl/positional_array_store_unit.sv */
// Insert and delete shift the entries from the position to the end of the
// list; search and read-all walk the entries up to the last beat.
// Throughput: one entry per cycle while shifting, or while scanning and the
// result stream is not stalled, set by the one read and one write port of the
// entry RAM; two items may wait in the queue.
// Reset: clears the count, the sequencer state and the valid flags; entries are not cleared.
// ----------------------------------------------------------------------------
// Positional array store unit
// Ordered list of signed 32-bit entries with append, insert, delete, search,
// read-all and clear, fed by a stream and answering on a stream.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_store_unit #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// position [6:0], value [38:7], zero [39]
	input  wire logic [39:0] s_axis_tdata,
	// mode [2:0]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// status [2:0], found_position [9:3], element [41:10], entry_count [48:42],
	// zero [55:49]
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tlast
);

	logic              q_full;
	logic              push;
	pasu_pkg::cmd_t    push_cmd;
	logic              q_pop;
	logic              q_valid;
	pasu_pkg::cmd_t    q_cmd;
	logic              res_valid;
	pasu_pkg::result_t res;

	pasu_front u_front (
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pasu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	pasu_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	// Pack the result beat
	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {7'd0, res.entry_count, res.element, res.found_position,
		res.status};
	assign m_axis_tlast  = res.last;

`ifndef ASSERT_OFF
	// Every error result closes its item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] != pasu_pkg::ST_OK) |-> m_axis_tlast)
		else $error("error status without last");

	// An error result has zero position and element
	a_err_noentry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] != pasu_pkg::ST_OK) |->
		(m_axis_tdata[9:3] == 7'd0) && (m_axis_tdata[41:10] == 32'd0))
		else $error("error result carries an entry");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Positional array store unit: stream testbench
// Plays directed and random append, insert, delete, search, read-all and
// clear beats into the list store. A model of the list predicts
// every result beat, and each beat that leaves the block is compared with the
// oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 64;
	localparam int GAP_MAX      = 18;
	localparam int RANDOM_ITEMS = 320;
	localparam int TAIL_CYCLES  = 2 * DEPTH + 32;
	localparam int SETTLE_MIN   = 4;
	localparam int DRAIN_GAP    = 3;

	// Modes the block ignores
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]  mode;
		logic [6:0]  pos;
		logic [31:0] val;
		int unsigned gap;
		bit          drain;
	} list_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	positional_array_store_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// Predicted list contents and the result beats still owed
	logic [31:0]       list_vals [DEPTH];
	logic [6:0]        list_len;
	pasu_pkg::result_t owed_beats [$];

	list_op_t    pending_ops [$];
	int          err_cnt = 0;
	longint      cycle_cnt = 0;
	longint      cycle_limit = 64'd100_000_000;
	logic        drained = 1'b0;

	// Generator-side state
	int          gen_len = 0;
	logic [31:0] value_pool [6];
	int          tx_phase_left = 0;
	bit          tx_calm = 1'b0;
	int          rx_phase_left = 0;
	bit          rx_calm = 1'b0;

	// Driver and monitor working state
	bit          tx_armed = 1'b0;
	int unsigned tx_hold = 0;
	bit          rx_armed = 1'b0;
	int unsigned rx_hold = 0;
	int          settle_cnt = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic owe_beat(input logic [2:0] st, input logic [6:0] fpos,
			input logic [31:0] el, input logic lst);
		pasu_pkg::result_t b;
		b.status         = st;
		b.found_position = fpos;
		b.element        = el;
		b.entry_count    = list_len;
		b.last           = lst;
		owed_beats.push_back(b);
	endtask

	// Apply one accepted operation to the list and queue the beats it owes
	task automatic apply_list_op(input logic [2:0] mode, input logic [6:0] pos,
			input logic [31:0] val);
		int i;
		int hits;
		int k;
		int lim;
		case (mode)
			pasu_pkg::MODE_APPEND: begin
				if (list_len >= DEPTH) begin
					owe_beat(pasu_pkg::ST_FULL, '0, '0, 1'b1);
				end else begin
					list_vals[list_len] = val;
					list_len++;
					owe_beat(pasu_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			pasu_pkg::MODE_INSERT: begin
				if (pos < 1 || pos > list_len) begin
					owe_beat(pasu_pkg::ST_BAD_POS, '0, '0, 1'b1);
				end else if (list_len >= DEPTH) begin
					owe_beat(pasu_pkg::ST_FULL, '0, '0, 1'b1);
				end else begin
					for (i = int'(list_len); i >= int'(pos); i--)
						list_vals[i] = list_vals[i-1];
					list_vals[pos-1] = val;
					list_len++;
					owe_beat(pasu_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			pasu_pkg::MODE_DELETE: begin
				if (list_len == 0) begin
					owe_beat(pasu_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else if (pos < 1 || pos > list_len) begin
					owe_beat(pasu_pkg::ST_BAD_POS, '0, '0, 1'b1);
				end else begin
					for (i = int'(pos) - 1; i + 1 < int'(list_len); i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
					owe_beat(pasu_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			pasu_pkg::MODE_SEARCH: begin
				hits = 0;
				for (i = 0; i < int'(list_len); i++)
					if (list_vals[i] == val && hits < int'(pasu_pkg::MaxOut))
						hits++;
				if (hits == 0) begin
					owe_beat(pasu_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					k = 0;
					for (i = 0; i < int'(list_len) && k < hits; i++) begin
						if (list_vals[i] == val) begin
							k++;
							owe_beat(pasu_pkg::ST_OK, 7'(i + 1), list_vals[i],
								k == hits);
						end
					end
				end
			end
			pasu_pkg::MODE_READ_ALL: begin
				if (list_len == 0) begin
					owe_beat(pasu_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					lim = (int'(list_len) < int'(pasu_pkg::MaxOut)) ?
						int'(list_len) : int'(pasu_pkg::MaxOut);
					for (i = 0; i < lim; i++)
						owe_beat(pasu_pkg::ST_OK, 7'(i + 1), list_vals[i], i == lim - 1);
				end
			end
			pasu_pkg::MODE_CLEAR: begin
				list_len = '0;
				owe_beat(pasu_pkg::ST_OK, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endtask

	// Queue one operation with its idle gap; track list length for shaping
	task automatic add_op(input logic [2:0] mode, input logic [6:0] pos,
			input logic [31:0] val, input bit drain);
		list_op_t op;
		if (tx_phase_left == 0) begin
			tx_calm = ($urandom_range(0, 2) == 0);
			tx_phase_left = $urandom_range(6, 40);
		end
		tx_phase_left--;
		op.mode  = mode;
		op.pos   = pos;
		op.val   = val;
		op.drain = drain;
		op.gap   = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
		if (drain && op.gap < DRAIN_GAP)
			op.gap = DRAIN_GAP;
		pending_ops.push_back(op);
		case (mode)
			pasu_pkg::MODE_APPEND: if (gen_len < DEPTH) gen_len++;
			pasu_pkg::MODE_INSERT:
				if (pos >= 1 && pos <= gen_len && gen_len < DEPTH) gen_len++;
			pasu_pkg::MODE_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
			pasu_pkg::MODE_CLEAR:  gen_len = 0;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	function automatic logic [6:0] pick_pos(input bit in_range);
		if (in_range && gen_len > 0)
			return 7'($urandom_range(1, gen_len));
		return 7'($urandom_range(0, 127));
	endfunction

	// Append until full, then hit the full cases and scan the whole list
	task automatic fill_list(input bit one_value, inout int n);
		logic [31:0] key;
		key = pick_value();
		while (gen_len < DEPTH) begin
			add_op(pasu_pkg::MODE_APPEND, pick_pos(1'b0),
				one_value ? key : pick_value(), 1'b0);
			n++;
		end
		add_op(pasu_pkg::MODE_APPEND, pick_pos(1'b0), pick_value(), 1'b0);
		add_op(pasu_pkg::MODE_INSERT, 7'($urandom_range(1, DEPTH)), pick_value(), 1'b0);
		add_op(pasu_pkg::MODE_SEARCH, pick_pos(1'b0), key, 1'b0);
		add_op(pasu_pkg::MODE_READ_ALL, pick_pos(1'b0), $urandom, 1'b0);
		n += 4;
	endtask

	// Present queued operations, honoring each one's idle gap
	always @(posedge clk or negedge arst_n) begin : tx_side
		list_op_t cur;
		logic     vld_n;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			tx_armed = 1'b0;
			tx_hold  = 0;
		end else begin
			vld_n = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready)
				vld_n = 1'b0;
			if (!vld_n && pending_ops.size() != 0) begin
				if (!tx_armed) begin
					tx_hold  = pending_ops[0].gap;
					tx_armed = 1'b1;
				end
				if (tx_hold != 0) begin
					tx_hold--;
				end else if (!pending_ops[0].drain || drained) begin
					cur = pending_ops.pop_front();
					s_axis_tdata <= {1'b0, cur.val, cur.pos};
					s_axis_tuser <= cur.mode;
					vld_n    = 1'b1;
					tx_armed = 1'b0;
				end
			end
			s_axis_tvalid <= vld_n;
		end
	end

	// Check result beats, predict accepted beats, and stall the result side
	always @(posedge clk or negedge arst_n) begin : rx_side
		pasu_pkg::result_t got;
		pasu_pkg::result_t want;
		logic              rdy_n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			drained       <= 1'b0;
			list_len = '0;
			owed_beats.delete();
			rx_armed   = 1'b0;
			rx_hold    = 0;
			settle_cnt = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status         = m_axis_tdata[2:0];
				got.found_position = m_axis_tdata[9:3];
				got.element        = m_axis_tdata[41:10];
				got.entry_count    = m_axis_tdata[48:42];
				got.last           = m_axis_tlast;
				if (owed_beats.size() == 0) begin
					$error("result beat with nothing expected: status=%0d pos=%0d elem=0x%0h",
						got.status, got.found_position, got.element);
					err_cnt++;
				end else begin
					want = owed_beats.pop_front();
					check_field("status", want.status, got.status);
					check_field("found_position", want.found_position, got.found_position);
					check_field("element", want.element, got.element);
					check_field("entry_count", want.entry_count, got.entry_count);
					check_field("last", want.last, got.last);
				end
				rx_armed = 1'b0;
			end

			if (s_axis_tvalid && s_axis_tready)
				apply_list_op(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[38:7]);

			// draw a fresh stall for every result beat
			if (!rx_armed) begin
				if (rx_phase_left == 0) begin
					rx_calm = ($urandom_range(0, 2) == 0);
					rx_phase_left = $urandom_range(8, 48);
				end
				rx_phase_left--;
				rx_hold  = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
				rx_armed = 1'b1;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				rdy_n = 1'b0;
			end else begin
				rdy_n = 1'b1;
			end
			m_axis_tready <= rdy_n;

			// flag a quiet block for the sender's drain pause
			if (owed_beats.size() == 0 && !s_axis_tvalid)
				settle_cnt++;
			else
				settle_cnt = 0;
			drained <= (settle_cnt >= SETTLE_MIN);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > cycle_limit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int r;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		value_pool[4] = $urandom;
		value_pool[5] = $urandom;

		// Directed: empty-list cases, ignored modes, edges of positions
		add_op(pasu_pkg::MODE_READ_ALL, 7'd0, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_DELETE, 7'd1, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_SEARCH, 7'd0, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_INSERT, 7'd1, 32'h1234_5678, 1'b0);
		add_op(MODE_SPARE_LO, 7'd0, 32'h0, 1'b0);
		add_op(MODE_SPARE_HI, 7'd127, 32'hffff_ffff, 1'b0);
		add_op(pasu_pkg::MODE_APPEND, 7'd0, 32'h8000_0000, 1'b0);
		add_op(pasu_pkg::MODE_APPEND, 7'd0, 32'h7fff_ffff, 1'b0);
		add_op(pasu_pkg::MODE_APPEND, 7'd0, 32'h0000_0000, 1'b0);
		add_op(pasu_pkg::MODE_INSERT, 7'd0, 32'h5555_5555, 1'b0);
		add_op(pasu_pkg::MODE_INSERT, 7'd1, 32'hffff_ffff, 1'b0);
		add_op(pasu_pkg::MODE_INSERT, 7'd4, 32'h0000_0005, 1'b0);
		add_op(pasu_pkg::MODE_INSERT, 7'd6, 32'haaaa_aaaa, 1'b0);
		add_op(pasu_pkg::MODE_APPEND, 7'd0, 32'hffff_ffff, 1'b0);
		add_op(pasu_pkg::MODE_SEARCH, 7'd0, 32'hffff_ffff, 1'b0);
		add_op(pasu_pkg::MODE_SEARCH, 7'd0, 32'h0001_2345, 1'b0);
		add_op(pasu_pkg::MODE_READ_ALL, 7'd0, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_DELETE, 7'd0, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_DELETE, 7'd127, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_DELETE, 7'd6, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_DELETE, 7'd1, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_READ_ALL, 7'd0, 32'h0, 1'b1);
		add_op(pasu_pkg::MODE_CLEAR, 7'd0, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_READ_ALL, 7'd0, 32'h0, 1'b0);
		add_op(pasu_pkg::MODE_APPEND, 7'd127, 32'h7fff_ffff, 1'b0);

		// Random: mostly in-range positions and pooled values so matches repeat
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n == 100) begin
				fill_list(1'b1, n);
			end else if (n == 220) begin
				fill_list(1'b0, n);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					add_op(pasu_pkg::MODE_APPEND, pick_pos(1'b0), pick_value(),
						n % 90 == 45);
				end else if (r < 52) begin
					add_op(pasu_pkg::MODE_INSERT, pick_pos($urandom_range(0, 9) < 8),
						pick_value(), n % 90 == 45);
				end else if (r < 70) begin
					add_op(pasu_pkg::MODE_DELETE, pick_pos($urandom_range(0, 9) < 8),
						$urandom, n % 90 == 45);
				end else if (r < 83) begin
					add_op(pasu_pkg::MODE_SEARCH, pick_pos(1'b0),
						($urandom_range(0, 3) != 0) ? pick_value() : $urandom, n % 90 == 45);
				end else if (r < 91) begin
					add_op(pasu_pkg::MODE_READ_ALL, pick_pos(1'b0), $urandom,
						n % 90 == 45);
				end else if (r < 94) begin
					add_op(pasu_pkg::MODE_CLEAR, pick_pos(1'b0), $urandom, n % 90 == 45);
				end else if (r < 96) begin
					// ignored modes do not count toward the item total
					add_op(r[0] ? MODE_SPARE_HI : MODE_SPARE_LO, pick_pos(1'b0), $urandom, 1'b0);
					n--;
				end else begin
					add_op(pasu_pkg::MODE_APPEND, pick_pos(1'b0), pick_value(),
						n % 90 == 45);
				end
				n++;
			end
		end

		// Every beat at its longest result burst, stalls and gaps, several times over
		cycle_limit = longint'(pending_ops.size())
			* (int'(pasu_pkg::MaxOut) * (GAP_MAX + 2) + GAP_MAX + DEPTH + 16) * 4 + 10_000;

		// Hold reset, then release it on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (owed_beats.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (owed_beats.size() != 0) begin
			$error("%0d expected result beats never arrived", owed_beats.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
